@@ sv/salc_pkg.sv @@
// Shared constants and types of the set-associative LRU cache lookup.
package salc_pkg;

    localparam int DefAddressBits = 16;
    localparam int DefBlockBytes  = 4;
    localparam int DefSets        = 16;
    localparam int DefWays        = 2;

    localparam int AddrFieldW = 16;
    localparam int TotalW     = 32;
    localparam int MDataW     = 72;

    // Outcome of one lookup, handed from the update logic to the top level.
    typedef struct packed {
        logic hit;
        logic way_lsb;
        logic evicted;
    } salc_res_t;

endpackage

@@ sv/salc_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/salc_update.sv @@
// Hit search, victim choice and recency update of one set row.
module salc_update #(
    parameter int WAYS   = salc_pkg::DefWays,
    parameter int TAG_W  = 10,
    parameter int RANK_W = 1
) (
    input  logic [WAYS*(1+TAG_W+RANK_W)-1:0] row_i,
    input  logic [TAG_W-1:0]                 tag_i,
    output logic [WAYS*(1+TAG_W+RANK_W)-1:0] row_o,
    output salc_pkg::salc_res_t              res_o
);

    localparam int LINE_W = 1 + TAG_W + RANK_W;

    logic [WAYS-1:0]   vld;
    logic [TAG_W-1:0]  tg [WAYS];
    logic [RANK_W-1:0] rk [WAYS];
    logic [RANK_W-1:0] rk_new [WAYS];
    logic              hit_found;
    logic              inv_found;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] inv_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] best;
    logic [RANK_W-1:0] sel_way;
    logic [RANK_W-1:0] old_rank;
    logic              was_valid;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            vld[w] = row_i[w*LINE_W];
            tg[w]  = row_i[w*LINE_W+1 +: TAG_W];
            rk[w]  = row_i[w*LINE_W+1+TAG_W +: RANK_W];
        end

        // Lowest matching way, lowest invalid way, and oldest way (lowest on a tie).
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        best      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_found && vld[w] && tg[w] == tag_i) begin
                hit_found = 1'b1;
                hit_way   = RANK_W'(w);
            end
            if (!inv_found && !vld[w]) begin
                inv_found = 1'b1;
                inv_way   = RANK_W'(w);
            end
            if (rk[w] > best) begin
                best    = rk[w];
                lru_way = RANK_W'(w);
            end
        end

        if (hit_found) begin
            sel_way = hit_way;
        end else if (inv_found) begin
            sel_way = inv_way;
        end else begin
            sel_way = lru_way;
        end
        was_valid = hit_found || !inv_found;
        old_rank  = rk[sel_way];

        // Lines younger than the touched one age by one; a fill of an invalid way ages every other valid line.
        for (int w = 0; w < WAYS; w++) begin
            rk_new[w] = rk[w];
            if (RANK_W'(w) == sel_way) begin
                rk_new[w] = '0;
            end else if (vld[w] && (!was_valid || rk[w] < old_rank)) begin
                rk_new[w] = RANK_W'(rk[w] + 1'b1);
            end
        end

        for (int w = 0; w < WAYS; w++) begin
            row_o[w*LINE_W]                     = vld[w] || (RANK_W'(w) == sel_way);
            row_o[w*LINE_W+1 +: TAG_W]          =
                (RANK_W'(w) == sel_way && !hit_found) ? tag_i : tg[w];
            row_o[w*LINE_W+1+TAG_W +: RANK_W]   = rk_new[w];
        end

        res_o.hit     = hit_found;
        res_o.way_lsb = sel_way[0];
        res_o.evicted = !hit_found && !inv_found;
    end

endmodule

@@ sv/set_assoc_lru_cache_lookup.sv @@
// Top level of the set-associative cache tag lookup with LRU replacement.
//
//  Channel | Direction | tdata fields (lowest bit first)
//  --------+-----------+---------------------------------------------------
//  s_      | in        | address[15:0]
//  m_      | out       | hit, way_used, victim_evicted, hit_total[31:0],
//          |           | miss_total[31:0], five zero bits
//
// Each item first gets a registered read of its set row from the tag RAM,
// then is compared, has its recency ranks updated and its row written back.
// With the single read-modify-write port pair of the tag RAM, a new item is
// taken only after the previous row is written back. After reset the block
// clears the tag RAM, one row per cycle, and takes no item during that pass.
// A stalled result is held in the output register; the next item is still
// accepted and waits in the update stage until the output register frees up.
module set_assoc_lru_cache_lookup #(
    parameter int ADDRESS_BITS = salc_pkg::DefAddressBits,
    parameter int BLOCK_BYTES  = salc_pkg::DefBlockBytes,
    parameter int SETS         = salc_pkg::DefSets,
    parameter int WAYS         = salc_pkg::DefWays
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [salc_pkg::AddrFieldW-1:0] s_tdata,   // address
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, way_used, victim_evicted, hit_total, miss_total, zero fill
    output logic [salc_pkg::MDataW-1:0]     m_tdata
);

    // Address split. Only the low ADDRESS_BITS bits of the field take part.
    localparam int EFF_W     = ADDRESS_BITS < salc_pkg::AddrFieldW ?
                               ADDRESS_BITS : salc_pkg::AddrFieldW;
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SET_W     = $clog2(SETS);
    localparam int SET_IDX_W = SET_W > 0 ? SET_W : 1;
    localparam int RAW_TAG   = EFF_W - OFF_W - SET_W;
    localparam int TAG_W     = RAW_TAG > 0 ? RAW_TAG : 1;
    localparam int EXT_W     = OFF_W + SET_W + TAG_W;
    localparam int RANK_W    = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int LINE_W    = 1 + TAG_W + RANK_W;
    localparam int ROW_W     = WAYS * LINE_W;

    localparam logic [salc_pkg::AddrFieldW:0] AMASK_EXT =
        (17'd1 << EFF_W) - 17'd1;
    localparam logic [EXT_W-1:0] SET_MASK = EXT_W'(SETS - 1);
    localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(SETS - 1);
    localparam logic [salc_pkg::TotalW-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                       state_reg, state_next;
    logic [SET_IDX_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [SET_IDX_W-1:0]         set_reg, set_next;
    logic [TAG_W-1:0]             tag_reg, tag_next;
    logic                         m_valid_reg, m_valid_next;
    logic [salc_pkg::TotalW-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [salc_pkg::TotalW-1:0]  miss_cnt_reg, miss_cnt_next;
    salc_pkg::salc_res_t          res_reg, res_next;

    logic [salc_pkg::AddrFieldW-1:0] addr_m;
    logic [EXT_W-1:0]             addr_ext;
    logic [SET_IDX_W-1:0]         in_set;
    logic [TAG_W-1:0]             in_tag;
    logic                         accept;
    logic                         commit;

    logic                         ram_we;
    logic [SET_IDX_W-1:0]         ram_waddr;
    logic [ROW_W-1:0]             ram_wdata;
    logic [ROW_W-1:0]             ram_rdata;
    logic [ROW_W-1:0]             row_upd;
    salc_pkg::salc_res_t          res_upd;

    // Block offset, set index and tag are plain bit fields of the address.
    assign addr_m   = s_tdata & AMASK_EXT[salc_pkg::AddrFieldW-1:0];
    assign addr_ext = EXT_W'(addr_m);
    assign in_set   = SET_IDX_W'((addr_ext >> OFF_W) & SET_MASK);
    assign in_tag   = TAG_W'(addr_ext >> (OFF_W + SET_W));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The update stage finishes once the output register can take its result.
    assign commit   = (state_reg == ST_LOOK) && (!m_valid_reg || m_tready);

    assign ram_we    = (state_reg == ST_CLEAR) || commit;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : row_upd;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    salc_update #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_update (
        .row_i (ram_rdata),
        .tag_i (tag_reg),
        .row_o (row_upd),
        .res_o (res_upd)
    );

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        res_next      = res_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = SET_IDX_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == LAST_SET) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    set_next   = in_set;
                    tag_next   = in_tag;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (commit) begin
                    res_next     = res_upd;
                    m_valid_next = 1'b1;
                    // Both totals saturate at their largest value.
                    if (res_upd.hit) begin
                        if (hit_cnt_reg != TOTAL_MAX) begin
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                        end
                    end else if (miss_cnt_reg != TOTAL_MAX) begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
        set_reg <= set_next;
        tag_reg <= tag_next;
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, miss_cnt_reg, hit_cnt_reg,
                       res_reg.evicted, res_reg.way_lsb, res_reg.hit};

endmodule

@@ bench/set_assoc_lru_cache_lookup_tb.sv @@
// Self-checking testbench for the set-associative LRU cache tag lookup.
module set_assoc_lru_cache_lookup_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DefAddressBits = salc_pkg::DefAddressBits;
    localparam int DefBlockBytes  = salc_pkg::DefBlockBytes;
    localparam int DefSets        = salc_pkg::DefSets;
    localparam int DefWays        = salc_pkg::DefWays;
    localparam int AddrFieldW     = salc_pkg::AddrFieldW;
    localparam int TotalW         = salc_pkg::TotalW;
    localparam int MDataW         = salc_pkg::MDataW;

    // Address split for the default geometry: offset, set index, tag.
    localparam int OffW  = $clog2(DefBlockBytes);
    localparam int SetW  = $clog2(DefSets);
    localparam int TagW  = DefAddressBits - OffW - SetW;
    localparam int CycleLimit = 200000;

    // One expected lookup result, in the field order of m_tdata.
    typedef struct packed {
        logic              hit;
        logic              way_used;
        logic              evicted;
        logic [TotalW-1:0] hit_total;
        logic [TotalW-1:0] miss_total;
    } lookup_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [AddrFieldW-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MDataW-1:0]     m_tdata;

    set_assoc_lru_cache_lookup DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Addresses waiting to be sent, and lookup results still owed by the block.
    logic [AddrFieldW-1:0] pending_addrs[$];
    lookup_t               owed_lookups[$];

    // Appends one address to the tail of the send queue.
    function automatic void queue_addr(logic [AddrFieldW-1:0] addr);
        pending_addrs = {pending_addrs, addr};
    endfunction

    // Shadow copy of the tag store. Ages are recency ranks, 0 is most recent.
    bit              line_ok [DefSets][DefWays];
    logic [TagW-1:0] line_key[DefSets][DefWays];
    int              line_age[DefSets][DefWays];
    logic [TotalW-1:0] hits_so_far   = '0;
    logic [TotalW-1:0] misses_so_far = '0;

    int  idle_pct    = 0;
    int  send_gap    = 0;
    int  take_gap    = 0;
    bit  addr_taken  = 1'b0;
    int  errors      = 0;
    int  results_seen = 0;
    int  hits_seen   = 0;
    int  evicts_seen = 0;
    int  cycles      = 0;

    // Make way w of a set the most recent line. Lines that were more recent
    // than w (or all valid lines, when w is freshly filled) age by one.
    function automatic void mark_recent(int set_idx, int w, bit was_valid);
        int prior;
        prior = line_age[set_idx][w];
        for (int v = 0; v < DefWays; v++) begin
            if (v != w && line_ok[set_idx][v] && (!was_valid || line_age[set_idx][v] < prior)) begin
                line_age[set_idx][v]++;
            end
        end
        line_age[set_idx][w] = 0;
    endfunction

    // Runs one access through the shadow tag store and returns what the block
    // must report for it.
    function automatic lookup_t predict_lookup(logic [AddrFieldW-1:0] addr);
        int          set_idx;
        logic [TagW-1:0] key;
        int          way;
        int          oldest;
        bit          found;
        lookup_t     res;
        set_idx = int'(addr[OffW +: SetW]);
        key     = addr[OffW + SetW +: TagW];
        found   = 1'b0;
        way     = 0;
        res     = '0;
        for (int w = 0; w < DefWays; w++) begin
            if (!found && line_ok[set_idx][w] && line_key[set_idx][w] == key) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (hits_so_far != '1) hits_so_far++;
            mark_recent(set_idx, way, 1'b1);
        end else begin
            if (misses_so_far != '1) misses_so_far++;
            for (int w = 0; w < DefWays; w++) begin
                if (!found && !line_ok[set_idx][w]) begin
                    found = 1'b1;
                    way   = w;
                end
            end
            if (found) begin
                mark_recent(set_idx, way, 1'b0);
                line_ok[set_idx][way] = 1'b1;
            end else begin
                // Full set: the line with the largest rank goes, lowest way on a tie.
                oldest = 0;
                way    = 0;
                for (int w = 0; w < DefWays; w++) begin
                    if (line_age[set_idx][w] > oldest) begin
                        oldest = line_age[set_idx][w];
                        way    = w;
                    end
                end
                res.evicted = 1'b1;
                mark_recent(set_idx, way, 1'b1);
            end
            line_key[set_idx][way] = key;
        end
        res.way_used   = way[0];
        res.hit_total  = hits_so_far;
        res.miss_total = misses_so_far;
        return res;
    endfunction

    function automatic logic [AddrFieldW-1:0] make_addr(logic [TagW-1:0] key,
                                                        logic [SetW-1:0] set_idx,
                                                        logic [OffW-1:0] offset);
        return {key, set_idx, offset};
    endfunction

    task automatic report_mismatch(string field, logic [TotalW-1:0] got,
                                   logic [TotalW-1:0] want);
        errors++;
        if (errors <= 25) begin
            $display("mismatch in %s at result %0d: got %0h, expected %0h",
                     field, results_seen, got, want);
        end
    endtask

    // Sender. A new address goes out only once the previous one was taken,
    // or when nothing is on the bus. Random bursts of idle cycles come between.
    always @(negedge aclk) begin : drive_addr
        logic                  nxt_valid;
        logic [AddrFieldW-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (aresetn && (!s_tvalid || addr_taken)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_addrs.size() > 0) begin
                if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    send_gap = $urandom_range(11, 0);
                end else begin
                    nxt_valid = 1'b1;
                    nxt_data  = pending_addrs.pop_front();
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;
    end

    // Receiver. Backpressure comes in random bursts.
    always @(negedge aclk) begin : drive_ready
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (take_gap > 0) begin
            take_gap--;
            nxt_ready = 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            take_gap  = $urandom_range(11, 0);
            nxt_ready = 1'b0;
        end
        m_tready <= nxt_ready;
    end

    // Monitor. Results are checked before the item accepted on the same edge
    // is predicted, since that item cannot have produced a result yet.
    always @(posedge aclk) begin : watch_channels
        lookup_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (owed_lookups.size() == 0) begin
                    report_mismatch("result with nothing outstanding", '0, '0);
                end else begin
                    want = owed_lookups.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch("hit", TotalW'(m_tdata[0]), TotalW'(want.hit));
                    if (m_tdata[1] !== want.way_used)
                        report_mismatch("way_used", TotalW'(m_tdata[1]),
                                        TotalW'(want.way_used));
                    if (m_tdata[2] !== want.evicted)
                        report_mismatch("victim_evicted", TotalW'(m_tdata[2]),
                                        TotalW'(want.evicted));
                    if (m_tdata[3 +: TotalW] !== want.hit_total)
                        report_mismatch("hit_total", m_tdata[3 +: TotalW], want.hit_total);
                    if (m_tdata[3 + TotalW +: TotalW] !== want.miss_total)
                        report_mismatch("miss_total", m_tdata[3 + TotalW +: TotalW],
                                        want.miss_total);
                    if (want.hit) hits_seen++;
                    if (want.evicted) evicts_seen++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                owed_lookups = {owed_lookups, predict_lookup(s_tdata)};
            end
            addr_taken <= s_tvalid && s_tready;
        end else begin
            addr_taken <= 1'b0;
        end
    end

    // Watchdog. The slowest legal run is far below this limit.
    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("[set_assoc_lru_cache_lookup] ERROR");
            $finish;
        end
    end

    // Waits until every queued address went out and every result came back.
    task automatic wait_drained();
        while (pending_addrs.size() != 0 || s_tvalid || owed_lookups.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Random traffic. Most of it is short runs on one set over a pool of
    // three tags, which with two ways gives hits, fills and evictions back
    // to back. The rest is scattered addresses.
    task automatic queue_traffic(int count);
        logic [SetW-1:0] home_set;
        logic [SetW-1:0] other_set;
        logic [TagW-1:0] pool[3];
        int              left;
        int              runs;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                queue_addr(AddrFieldW'($urandom));
                left--;
            end else begin
                home_set  = SetW'($urandom);
                other_set = SetW'($urandom);
                foreach (pool[i]) begin
                    case ($urandom_range(7))
                        0:       pool[i] = '0;
                        1:       pool[i] = '1;
                        default: pool[i] = TagW'($urandom);
                    endcase
                end
                runs = $urandom_range(10, 3);
                while (runs > 0 && left > 0) begin
                    queue_addr(make_addr(pool[$urandom_range(2)],
                        ($urandom_range(9) == 0) ? other_set : home_set, OffW'($urandom)));
                    runs--;
                    left--;
                end
            end
        end
    endtask

    initial begin : stimulus
        int chunk_pct[5];
        foreach (line_ok[s, w]) begin
            line_ok[s][w]  = 1'b0;
            line_key[s][w] = '0;
            line_age[s][w] = 0;
        end
        chunk_pct = '{20, 0, 50, 10, 35};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Set 0 walks through fill of both ways, a hit that
        // reorders the ranks, and two evictions of the least recent line.
        // The all-ones address and the extreme tags and offsets come next.
        idle_pct = 30;
        queue_addr(make_addr('0, 4'h0, 2'd0));
        queue_addr(make_addr('0, 4'h0, 2'd3));
        queue_addr(make_addr('1, 4'h0, 2'd1));
        queue_addr(make_addr('0, 4'h0, 2'd2));
        queue_addr(make_addr(10'd5, 4'h0, 2'd0));
        queue_addr(make_addr('1, 4'h0, 2'd0));
        queue_addr(make_addr(10'd5, 4'h0, 2'd3));
        queue_addr(make_addr('1, 4'h0, 2'd3));
        queue_addr(16'hFFFF);
        queue_addr(16'hFFFC);
        queue_addr(make_addr('0, 4'hF, 2'd0));
        queue_addr(16'hFFFE);
        queue_addr(make_addr(10'h155, 4'hA, 2'd1));
        queue_addr(make_addr(10'h2AA, 4'h5, 2'd2));
        queue_addr(make_addr(10'h2AA, 4'hA, 2'd2));
        queue_addr(make_addr(10'h155, 4'hA, 2'd0));
        queue_addr(make_addr(10'h3F0, 4'hA, 2'd3));
        queue_addr(make_addr(10'h2AA, 4'hA, 2'd1));
        queue_addr(make_addr(10'h155, 4'h5, 2'd0));
        queue_addr(make_addr(10'h155, 4'h5, 2'd0));
        queue_addr(16'h0000);
        wait_drained();

        // Random part in chunks, each with its own amount of idling. After the
        // second chunk the sender holds back until the block has fully drained.
        for (int c = 0; c < 5; c++) begin
            while (pending_addrs.size() != 0) @(posedge aclk);
            if (c == 2) wait_drained();
            idle_pct = chunk_pct[c];
            queue_traffic(250);
        end
        while (pending_addrs.size() != 0) @(posedge aclk);
        idle_pct = 0;
        queue_traffic(300);

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Checked %0d lookups: %0d hits, %0d misses, %0d of them LRU evictions.",
                 results_seen, hits_seen, results_seen - hits_seen, evicts_seen);
        $display("Traffic mixed set-local tag pools, scattered addresses and idle bursts.");
        if (errors == 0) begin
            $display("[set_assoc_lru_cache_lookup] OK");
        end else begin
            $display("[set_assoc_lru_cache_lookup] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/salc_pkg.sv
sv/salc_ram.sv
sv/salc_update.sv
sv/set_assoc_lru_cache_lookup.sv
bench/set_assoc_lru_cache_lookup_tb.sv
